// ===== sv/bgd_pkg.sv =====
// ----------------------------------------------------------------------------
// bgd_pkg
// Shared constants, action codes and types for the button gesture and
// detent dispatcher.
// ----------------------------------------------------------------------------
package bgd_pkg;

	localparam int TIME_BITS   = 32;
	localparam int PRESET_KEYS = 4;
	localparam int PRESET_BITS = 4;
	localparam int PRESET_USED = (PRESET_KEYS < PRESET_BITS) ? PRESET_KEYS : PRESET_BITS;

	localparam logic [15:0] HOLD_RST = 16'd2000;
	localparam logic [15:0] TAP_RST  = 16'd500;
	localparam logic [7:0]  CPD_RST  = 8'd4;

	typedef enum logic [3:0] {
		ACT_NONE       = 4'd0,
		ACT_START_STOP = 4'd1,
		ACT_RESET      = 4'd2,
		ACT_PRESET1    = 4'd3,
		ACT_PRESET2    = 4'd4,
		ACT_PRESET3    = 4'd5,
		ACT_PRESET4    = 4'd6,
		ACT_SELECT     = 4'd7,
		ACT_NEXT       = 4'd8,
		ACT_PREV       = 4'd9,
		ACT_CONFIRM    = 4'd10,
		ACT_BRIGHTNESS = 4'd11
	} action_t;

	typedef enum logic [1:0] {
		MODE_RUN     = 2'd0,
		MODE_SPORT   = 2'd1,
		MODE_VARIANT = 2'd2,
		MODE_OTHER   = 2'd3
	} mode_t;

	typedef enum logic [1:0] {
		REG_HOLD = 2'd0,
		REG_TAP  = 2'd1,
		REG_CPD  = 2'd2
	} cfg_reg_t;

	typedef struct packed {
		logic [TIME_BITS-1:0]   now;
		mode_t                  mode;
		logic                   start_edge;
		logic                   reset_edge;
		logic [PRESET_BITS-1:0] presets;
		logic                   pressed;
		logic [31:0]            pos;
		logic                   click;
	} poll_t;

	typedef struct packed {
		logic [15:0] hold_ms;
		logic [15:0] tap_ms;
		logic [7:0]  cpd;
	} cfg_t;

endpackage

// ===== sv/bgd_gesture.sv =====
// ----------------------------------------------------------------------------
// bgd_gesture
// Control button gesture tracker: hold, short press and double tap. State
// advances only on commit.
// ----------------------------------------------------------------------------
module bgd_gesture (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          commit,
	input  logic [bgd_pkg::TIME_BITS-1:0] now,
	input  logic                          pressed,
	input  bgd_pkg::cfg_t                 cfg,
	output bgd_pkg::action_t              act
);
	import bgd_pkg::*;

	logic                 active_q;
	logic [TIME_BITS-1:0] start_q;
	logic [TIME_BITS-1:0] last_q;
	logic [1:0]           tally_q;

	logic                 active_d;
	logic [TIME_BITS-1:0] start_d;
	logic [TIME_BITS-1:0] last_d;
	logic [1:0]           tally_d;
	logic                 rise;
	logic [TIME_BITS-1:0] el_start;
	logic [TIME_BITS-1:0] el_last;
	logic [TIME_BITS-1:0] hold_t;
	logic [TIME_BITS-1:0] tap_t;

	assign rise   = !active_q && pressed;
	assign hold_t = TIME_BITS'(cfg.hold_ms);
	assign tap_t  = TIME_BITS'(cfg.tap_ms);

	always_comb begin
		active_d = active_q;
		start_d  = start_q;
		last_d   = last_q;
		tally_d  = tally_q;
		act      = ACT_NONE;
		if (rise) begin
			active_d = 1'b1;
			start_d  = now;
			last_d   = now;
			if (tally_q != 2'd3)
				tally_d = tally_q + 2'd1;
		end
		el_start = now - start_d;
		el_last  = now - last_d;
		if (pressed && el_start >= hold_t) begin
			active_d = 1'b0;
			tally_d  = 2'd0;
			act      = ACT_RESET;
		end else if (active_d && !pressed && el_start < hold_t) begin
			active_d = 1'b0;
			act      = ACT_START_STOP;
		end else begin
			if (active_d && !pressed) begin
				active_d = 1'b0;
				tally_d  = 2'd0;
			end
			if (tally_d == 2'd2 && el_last < tap_t) begin
				tally_d = 2'd0;
				act     = ACT_SELECT;
			end else if (tally_d == 2'd1 && el_last > tap_t) begin
				tally_d = 2'd0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= 1'b0;
			start_q  <= '0;
			last_q   <= '0;
			tally_q  <= 2'd0;
		end else if (commit) begin
			active_q <= active_d;
			start_q  <= start_d;
			last_q   <= last_d;
			tally_q  <= tally_d;
		end
	end

	a_hold_clears: assert property (@(posedge clk) disable iff (!arst_n)
		commit && act == ACT_RESET |=> !active_q && tally_q == 2'd0)
		else $error("hold did not clear gesture state");

	a_short_keeps_tally: assert property (@(posedge clk) disable iff (!arst_n)
		commit && act == ACT_START_STOP |=> !active_q && tally_q == $past(tally_q))
		else $error("short press altered tally");

	a_idle_holds: assert property (@(posedge clk) disable iff (!arst_n)
		!commit |=> $stable(tally_q) && $stable(active_q) && $stable(start_q))
		else $error("gesture state moved without commit");

endmodule

// ===== sv/bgd_detent.sv =====
// ----------------------------------------------------------------------------
// bgd_detent
// Encoder detent tracker: compares the encoder count with the consumed
// position and drains or swallows the backlog per UI mode.
// ----------------------------------------------------------------------------
module bgd_detent (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             commit,
	input  bgd_pkg::mode_t   mode,
	input  logic [31:0]      pos,
	input  logic [7:0]       cpd,
	output bgd_pkg::action_t act
);
	import bgd_pkg::*;

	logic [31:0]        consumed_q;
	logic [31:0]        consumed_d;
	logic [7:0]         step;
	logic [31:0]        diff;
	logic signed [31:0] diff_s;
	logic signed [31:0] step_s;
	logic               big;

	assign step   = (cpd == 8'd0) ? 8'd1 : cpd;
	assign diff   = pos - consumed_q;
	assign diff_s = signed'(diff);
	assign step_s = signed'(32'(step));
	assign big    = (diff_s >= step_s) || (diff_s <= -step_s);

	always_comb begin
		consumed_d = consumed_q;
		act        = ACT_NONE;
		if (big) begin
			case (mode)
				MODE_RUN: begin
					consumed_d = pos;
					act        = ACT_SELECT;
				end
				MODE_SPORT, MODE_VARIANT: begin
					if (!diff[31]) begin
						consumed_d = consumed_q + 32'(step);
						act        = ACT_NEXT;
					end else begin
						consumed_d = consumed_q - 32'(step);
						act        = ACT_PREV;
					end
				end
				default: begin
					consumed_d = pos;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			consumed_q <= '0;
		else if (commit)
			consumed_q <= consumed_d;
	end

	a_next_steps: assert property (@(posedge clk) disable iff (!arst_n)
		commit && act == ACT_NEXT |=> consumed_q == $past(consumed_q) + 32'($past(step)))
		else $error("next detent did not advance by one step");

	a_run_swallows: assert property (@(posedge clk) disable iff (!arst_n)
		commit && act == ACT_SELECT |=> consumed_q == $past(pos))
		else $error("running mode did not swallow backlog");

	a_no_move_idle: assert property (@(posedge clk) disable iff (!arst_n)
		!commit |=> $stable(consumed_q))
		else $error("consumed position moved without commit");

endmodule

// ===== sv/button_gesture_and_detent_dispatcher.sv =====
// ----------------------------------------------------------------------------
// button_gesture_and_detent_dispatcher
// Poll dispatcher: one action code per poll by fixed priority.
// ----------------------------------------------------------------------------
// One poll in, one action out. A poll is taken into an input register, then
// all decoding (key priority, control button gestures, encoder detents,
// click) runs in one pass of logic into the action register, while the
// gesture and detent state update on the same edge. Throughput is one poll
// per clock while the output is not stalled; a poll passes through the input
// register and then the action register. The input side keeps taking beats
// while a finished action waits, as long as the input register is empty or
// can drain into the action register. Configuration writes are registered;
// cfg_ready is always high.
module button_gesture_and_detent_dispatcher (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [1:0]                      cfg_index,
	input  logic [15:0]                     cfg_data,
	input  logic                            in_valid,
	output logic                            in_ready,
	input  logic [31:0]                     now_ms,
	input  logic [1:0]                      ui_mode,
	input  logic                            start_edge,
	input  logic                            reset_edge,
	input  logic [bgd_pkg::PRESET_BITS-1:0] preset_edges,
	input  logic                            control_pressed,
	input  logic signed [31:0]              encoder_position,
	input  logic                            encoder_click,
	output logic                            out_valid,
	input  logic                            out_ready,
	output logic [3:0]                      action
);
	import bgd_pkg::*;

	cfg_t    cfg_q;
	poll_t   poll_s1;
	logic    valid_s1;
	logic    out_valid_q;
	action_t action_q;

	logic    adv;
	logic    front_hit;
	action_t front_act;
	action_t gest_act;
	action_t det_act;
	action_t next_act;
	logic    gest_commit;
	logic    det_commit;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.hold_ms <= HOLD_RST;
			cfg_q.tap_ms  <= TAP_RST;
			cfg_q.cpd     <= CPD_RST;
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_HOLD: cfg_q.hold_ms <= cfg_data;
				REG_TAP:  cfg_q.tap_ms  <= cfg_data;
				REG_CPD:  cfg_q.cpd     <= cfg_data[7:0];
				default: ;
			endcase
		end
	end

	assign adv      = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready = !valid_s1 || adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s1 <= 1'b0;
		else if (in_ready)
			valid_s1 <= in_valid;
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			poll_s1.now        <= now_ms[TIME_BITS-1:0];
			poll_s1.mode       <= mode_t'(ui_mode);
			poll_s1.start_edge <= start_edge;
			poll_s1.reset_edge <= reset_edge;
			poll_s1.presets    <= preset_edges;
			poll_s1.pressed    <= control_pressed;
			poll_s1.pos        <= encoder_position;
			poll_s1.click      <= encoder_click;
		end
	end

	always_comb begin
		front_act = ACT_NONE;
		front_hit = 1'b1;
		if (poll_s1.start_edge) begin
			front_act = ACT_START_STOP;
		end else if (poll_s1.reset_edge) begin
			front_act = ACT_RESET;
		end else begin
			front_hit = 1'b0;
			for (int i = PRESET_USED - 1; i >= 0; i--) begin
				if (poll_s1.presets[i]) begin
					front_hit = 1'b1;
					front_act = action_t'(4'(int'(ACT_PRESET1) + i));
				end
			end
		end
	end

	assign gest_commit = adv && !front_hit && poll_s1.mode == MODE_RUN;
	assign det_commit  = adv && !front_hit &&
		!(poll_s1.mode == MODE_RUN && gest_act != ACT_NONE);

	bgd_gesture u_gesture (
		.clk     (clk),
		.arst_n  (arst_n),
		.commit  (gest_commit),
		.now     (poll_s1.now),
		.pressed (poll_s1.pressed),
		.cfg     (cfg_q),
		.act     (gest_act)
	);

	bgd_detent u_detent (
		.clk    (clk),
		.arst_n (arst_n),
		.commit (det_commit),
		.mode   (poll_s1.mode),
		.pos    (poll_s1.pos),
		.cpd    (cfg_q.cpd),
		.act    (det_act)
	);

	always_comb begin
		next_act = ACT_NONE;
		if (front_hit)
			next_act = front_act;
		else if (poll_s1.mode == MODE_RUN && gest_act != ACT_NONE)
			next_act = gest_act;
		else if (det_act != ACT_NONE)
			next_act = det_act;
		else if (poll_s1.click) begin
			if (poll_s1.mode inside {MODE_SPORT, MODE_VARIANT})
				next_act = ACT_CONFIRM;
			else if (poll_s1.mode == MODE_RUN)
				next_act = ACT_BRIGHTNESS;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (adv)
			out_valid_q <= 1'b1;
		else if (out_ready)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (adv)
			action_q <= next_act;
	end

	assign out_valid = out_valid_q;
	assign action    = action_q;

	a_rise_from_adv: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(adv))
		else $error("action beat without a poll behind it");

	a_s1_held: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !adv |=> valid_s1 && $stable(poll_s1))
		else $error("stalled poll lost");

	a_start_wins: assert property (@(posedge clk) disable iff (!arst_n)
		adv && poll_s1.start_edge |=> action_q == ACT_START_STOP)
		else $error("start key lost priority");

	a_no_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |-> !valid_s1 || adv)
		else $error("input beat overwrote a pending poll");

endmodule
